// File: rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, widths, command codes and helpers of the two-wheel motion
// setpoint sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int SP_WIDTH     = 16;
    localparam int SENSOR_WIDTH = 10;

    localparam int OUT_W      = 16;
    localparam int CMD_W      = 3;
    localparam int PAIR_W     = 8;
    localparam int NIB_W      = 4;
    localparam int COUNT_W    = 15;
    localparam int LVL_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LED_W      = 2;

    // width of the correction dividend magnitude
    localparam int DIV_N = (SENSOR_WIDTH > LVL_W) ? SENSOR_WIDTH : LVL_W;

    // working width for setpoint arithmetic before saturation
    localparam int CALC_A = (SP_WIDTH > COUNT_W + 1) ? SP_WIDTH : COUNT_W + 1;
    localparam int CALC_W = ((CALC_A > DIV_N + 1) ? CALC_A : DIV_N + 1) + 2;

    // exact reciprocal for n / 100 and n / 50 with n below 2**DIV_N
    localparam int Q_SHIFT100 = DIV_N + 7;
    localparam int Q_SHIFT50  = DIV_N + 6;
    localparam int RECIP_W    = DIV_N + 1;
    localparam int RECIP_I    = ((2 ** Q_SHIFT100) + 99) / 100;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
    localparam int PROD_W     = DIV_N + RECIP_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_NEAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_FAR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_CENTER = 3'd6;

    // configuration reset values
    localparam logic [COUNT_W-1:0] RST_CELL_COUNT  = 15'd2000;
    localparam logic [COUNT_W-1:0] RST_TURN_COUNT  = 15'd600;
    localparam logic [LVL_W-1:0]   RST_STEP_SIZE   = 10'd20;
    localparam logic [LVL_W-1:0]   RST_WALL_THRESH = 10'd300;
    localparam logic [LVL_W-1:0]   RST_FRONT_NEAR  = 10'd380;
    localparam logic [LVL_W-1:0]   RST_FRONT_FAR   = 10'd100;
    localparam logic [LVL_W-1:0]   RST_SIDE_CENTER = 10'd550;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE    = 3'd0,
        CMD_FWD     = 3'd1,
        CMD_LEFT    = 3'd2,
        CMD_RIGHT   = 3'd3,
        CMD_FWDWAIT = 3'd4,
        CMD_FOLLOW  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] cell_count;
        logic [COUNT_W-1:0] turn_count;
        logic [LVL_W-1:0]   step_size;
        logic [LVL_W-1:0]   wall_threshold;
        logic [LVL_W-1:0]   front_near_limit;
        logic [LVL_W-1:0]   front_far_limit;
        logic [LVL_W-1:0]   side_center_level;
    } t_cfg;

    typedef struct packed {
        logic                    action;
        logic [PAIR_W-1:0]       command_pair;
        logic [SENSOR_WIDTH-1:0] front_ir;
        logic [SENSOR_WIDTH-1:0] left_ir;
        logic [SENSOR_WIDTH-1:0] right_ir;
        logic                    front_wall;
        logic                    left_wall;
        logic                    right_wall;
    } t_item;

    typedef struct packed {
        t_cmd                       cmd;
        logic [PAIR_W-1:0]          pair;
        logic signed [SP_WIDTH-1:0] left_sp;
        logic signed [SP_WIDTH-1:0] right_sp;
        logic [LED_W-1:0]           leds;
    } t_state;

    typedef struct packed {
        t_cmd finished;
        logic moved_cell;
    } t_event;

    // clamp a working value to the signed setpoint range
    function automatic logic signed [SP_WIDTH-1:0] sat(input logic signed [CALC_W-1:0] v);
        logic [CALC_W-SP_WIDTH:0] upper;
        upper = v[CALC_W-1:SP_WIDTH-1];
        if ((&upper) || !(|upper)) begin
            sat = v[SP_WIDTH-1:0];
        end else if (v[CALC_W-1]) begin
            sat = {1'b1, {(SP_WIDTH-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SP_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

// File: rtl/motion_setpoint_sequencer_core.sv
// ----------------------------------------------------------------------------
// motion_setpoint_sequencer_core
// Two-wheel motion sequencer: runs queued commands and ramps both wheel
// setpoints once per control tick, reporting each completed command.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  input    | i_in_valid / o_in_ready     | i_action .. i_right_wall
//  result   | o_out_valid / i_out_ready   | o_left_target .. o_right_lamp
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while results are taken; an accepted item
//  passes through the input register, then the step logic into the result
//  register.
//  The step logic updates the sequencer state in the cycle it fills the
//  result register, so consecutive items chain through the state directly.
//  A stalled result holds the input register; the input side takes a new
//  transaction in the same cycle the result is taken.
//  Synchronous active-low reset restores registers, state and empty stages;
//  both ready outputs stay low while reset is held.
// ----------------------------------------------------------------------------
module motion_setpoint_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [mss_pkg::PAIR_W-1:0]          i_command_pair,
    input  logic [mss_pkg::SENSOR_WIDTH-1:0]    i_front_ir,
    input  logic [mss_pkg::SENSOR_WIDTH-1:0]    i_left_ir,
    input  logic [mss_pkg::SENSOR_WIDTH-1:0]    i_right_ir,
    input  logic                                i_front_wall,
    input  logic                                i_left_wall,
    input  logic                                i_right_wall,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mss_pkg::OUT_W-1:0]    o_left_target,
    output logic signed [mss_pkg::OUT_W-1:0]    o_right_target,
    output logic [mss_pkg::CMD_W-1:0]           o_active_command,
    output logic [mss_pkg::CMD_W-1:0]           o_finished,
    output logic                                o_moved_cell,
    output logic                                o_left_lamp,
    output logic                                o_right_lamp,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    mss_pkg::t_cfg   r_cfg, n_cfg;
    mss_pkg::t_state r_state;
    mss_pkg::t_state n_state;
    mss_pkg::t_event n_event;
    mss_pkg::t_item  r_in, n_in;
    mss_pkg::t_state r_out_state;
    mss_pkg::t_event r_out_event;
    logic            r_in_valid, r_out_valid;
    logic            out_free, advance, in_take, cfg_take;
    logic signed [mss_pkg::SP_WIDTH+mss_pkg::OUT_W-1:0] left_ext, right_ext;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = i_rst_n && (!r_in_valid || advance);
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;
    assign cfg_take   = i_cfg_valid && o_cfg_ready;

    assign n_in = '{
        action:       i_action,
        command_pair: i_command_pair,
        front_ir:     i_front_ir,
        left_ir:      i_left_ir,
        right_ir:     i_right_ir,
        front_wall:   i_front_wall,
        left_wall:    i_left_wall,
        right_wall:   i_right_wall
    };

    mss_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_event (n_event)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_take) begin
            unique case (i_cfg_index)
                mss_pkg::CFG_CELL_COUNT:  n_cfg.cell_count        = i_cfg_data[mss_pkg::COUNT_W-1:0];
                mss_pkg::CFG_TURN_COUNT:  n_cfg.turn_count        = i_cfg_data[mss_pkg::COUNT_W-1:0];
                mss_pkg::CFG_STEP_SIZE:   n_cfg.step_size         = i_cfg_data[mss_pkg::LVL_W-1:0];
                mss_pkg::CFG_WALL_THRESH: n_cfg.wall_threshold    = i_cfg_data[mss_pkg::LVL_W-1:0];
                mss_pkg::CFG_FRONT_NEAR:  n_cfg.front_near_limit  = i_cfg_data[mss_pkg::LVL_W-1:0];
                mss_pkg::CFG_FRONT_FAR:   n_cfg.front_far_limit   = i_cfg_data[mss_pkg::LVL_W-1:0];
                mss_pkg::CFG_SIDE_CENTER: n_cfg.side_center_level = i_cfg_data[mss_pkg::LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_count        <= mss_pkg::RST_CELL_COUNT;
            r_cfg.turn_count        <= mss_pkg::RST_TURN_COUNT;
            r_cfg.step_size         <= mss_pkg::RST_STEP_SIZE;
            r_cfg.wall_threshold    <= mss_pkg::RST_WALL_THRESH;
            r_cfg.front_near_limit  <= mss_pkg::RST_FRONT_NEAR;
            r_cfg.front_far_limit   <= mss_pkg::RST_FRONT_FAR;
            r_cfg.side_center_level <= mss_pkg::RST_SIDE_CENTER;
            r_state.cmd             <= mss_pkg::CMD_NONE;
            r_state.pair            <= '0;
            r_state.left_sp         <= '0;
            r_state.right_sp        <= '0;
            r_state.leds            <= '0;
            r_in_valid              <= 1'b0;
            r_out_valid             <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (advance) begin
                r_state <= n_state;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= n_in;
        end
        if (advance) begin
            r_out_state <= n_state;
            r_out_event <= n_event;
        end
    end

    assign left_ext  = (mss_pkg::SP_WIDTH + mss_pkg::OUT_W)'(r_out_state.left_sp);
    assign right_ext = (mss_pkg::SP_WIDTH + mss_pkg::OUT_W)'(r_out_state.right_sp);

    assign o_out_valid      = r_out_valid;
    assign o_left_target    = left_ext[mss_pkg::OUT_W-1:0];
    assign o_right_target   = right_ext[mss_pkg::OUT_W-1:0];
    assign o_active_command = r_out_state.cmd;
    assign o_finished       = r_out_event.finished;
    assign o_moved_cell     = r_out_event.moved_cell;
    assign o_left_lamp      = r_out_state.leds[0];
    assign o_right_lamp     = r_out_state.leds[1];

endmodule

// File: rtl/mss_step.sv
// ----------------------------------------------------------------------------
// mss_step
// Next-state logic of the sequencer: idle load, per-command setpoint ramps,
// wall-following corrections and completion events, for one item.
// ----------------------------------------------------------------------------
module mss_step (
    input  mss_pkg::t_state i_state,
    input  mss_pkg::t_item  i_item,
    input  mss_pkg::t_cfg   i_cfg,
    output mss_pkg::t_state o_state,
    output mss_pkg::t_event o_event
);

    logic                               load;
    logic [mss_pkg::NIB_W-1:0]          first;
    mss_pkg::t_cmd                      cmd0;
    logic [mss_pkg::PAIR_W-1:0]         pair0;
    logic signed [mss_pkg::CALC_W-1:0]  ls0, rs0;
    logic signed [mss_pkg::CALC_W-1:0]  step_x, cell_x, turn_x, half_x;
    logic signed [mss_pkg::CALC_W-1:0]  ls_inc, rs_inc, ls_dec, rs_dec;
    logic signed [mss_pkg::SP_WIDTH-1:0] ls_inc_s, rs_inc_s, ls_abs;
    logic signed [mss_pkg::SP_WIDTH-1:0] ls_tl, rs_tl, ls_tr, rs_tr;
    logic signed [mss_pkg::SP_WIDTH-1:0] ls_f, rs_f;
    logic                               r_lt_cell, r_lt_turn, l_lt_turn, r_gt_half;
    logic [mss_pkg::DIV_N-1:0]          fir, far_lvl, near_lvl;
    logic                               follow_go;

    // wall-following correction, one constant divider per side
    logic                               both;
    logic [mss_pkg::DIV_N-1:0]          ref_lvl;
    logic signed [mss_pkg::DIV_N:0]     diff_l, diff_r;
    logic [mss_pkg::DIV_N:0]            abs_l, abs_r;
    logic [mss_pkg::DIV_N-1:0]          mag_l, mag_r;
    logic [mss_pkg::PROD_W-1:0]         prod_l, prod_r, sh_l, sh_r;
    logic [mss_pkg::DIV_N-1:0]          q_l, q_r;
    logic signed [mss_pkg::CALC_W-1:0]  qx_l, qx_r, qs_l, qs_r;
    logic signed [mss_pkg::CALC_W-1:0]  corr_l, corr_r;

    // idle load of the next queued command
    assign load  = (i_state.cmd == mss_pkg::CMD_NONE);
    assign first = i_state.pair[mss_pkg::NIB_W-1:0];
    assign cmd0  = !load ? i_state.cmd :
                   (first <= mss_pkg::NIB_W'(mss_pkg::CMD_FOLLOW)) ?
                   mss_pkg::t_cmd'(first[mss_pkg::CMD_W-1:0]) : mss_pkg::CMD_NONE;
    assign pair0 = load ? {{mss_pkg::NIB_W{1'b0}}, i_state.pair[mss_pkg::PAIR_W-1:mss_pkg::NIB_W]}
                        : i_state.pair;
    assign ls0   = load ? '0 : mss_pkg::CALC_W'(i_state.left_sp);
    assign rs0   = load ? '0 : mss_pkg::CALC_W'(i_state.right_sp);

    assign step_x = signed'(mss_pkg::CALC_W'(i_cfg.step_size));
    assign cell_x = signed'(mss_pkg::CALC_W'(i_cfg.cell_count));
    assign turn_x = signed'(mss_pkg::CALC_W'(i_cfg.turn_count));
    assign half_x = signed'(mss_pkg::CALC_W'(i_cfg.cell_count >> 1));

    assign ls_inc = ls0 + step_x;
    assign rs_inc = rs0 + step_x;
    assign ls_dec = ls0 - step_x;
    assign rs_dec = rs0 - step_x;

    assign ls_inc_s = mss_pkg::sat(ls_inc);
    assign rs_inc_s = mss_pkg::sat(rs_inc);
    assign ls_abs   = ls_inc_s[mss_pkg::SP_WIDTH-1] ?
                      mss_pkg::sat(-mss_pkg::CALC_W'(ls_inc_s)) : ls_inc_s;

    // turns clamp at the turn count before saturation
    assign rs_tl = mss_pkg::sat((rs_inc > turn_x) ? turn_x : rs_inc);
    assign ls_tl = mss_pkg::sat((ls_dec < -turn_x) ? -turn_x : ls_dec);
    assign ls_tr = mss_pkg::sat((ls_inc > turn_x) ? turn_x : ls_inc);
    assign rs_tr = mss_pkg::sat((rs_dec < -turn_x) ? -turn_x : rs_dec);

    assign r_lt_cell = (rs0 < cell_x);
    assign r_lt_turn = (rs0 < turn_x);
    assign l_lt_turn = (ls0 < turn_x);
    assign r_gt_half = (rs0 > half_x);

    assign fir       = mss_pkg::DIV_N'(i_item.front_ir);
    assign far_lvl   = mss_pkg::DIV_N'(i_cfg.front_far_limit);
    assign near_lvl  = mss_pkg::DIV_N'(i_cfg.front_near_limit);
    assign follow_go = ((fir > far_lvl) && (fir < near_lvl)) || ((fir <= far_lvl) && r_lt_cell);

    assign both    = i_item.left_wall && i_item.right_wall;
    assign ref_lvl = both ? mss_pkg::DIV_N'(i_cfg.wall_threshold)
                          : mss_pkg::DIV_N'(i_cfg.side_center_level);
    assign diff_l  = signed'({1'b0, mss_pkg::DIV_N'(i_item.left_ir)}) - signed'({1'b0, ref_lvl});
    assign diff_r  = signed'({1'b0, mss_pkg::DIV_N'(i_item.right_ir)}) - signed'({1'b0, ref_lvl});
    assign abs_l   = diff_l[mss_pkg::DIV_N] ? -diff_l : diff_l;
    assign abs_r   = diff_r[mss_pkg::DIV_N] ? -diff_r : diff_r;
    assign mag_l   = abs_l[mss_pkg::DIV_N-1:0];
    assign mag_r   = abs_r[mss_pkg::DIV_N-1:0];
    assign prod_l  = mss_pkg::PROD_W'(mag_l) * mss_pkg::PROD_W'(mss_pkg::RECIP);
    assign prod_r  = mss_pkg::PROD_W'(mag_r) * mss_pkg::PROD_W'(mss_pkg::RECIP);
    // same reciprocal serves both divisors: one more shift for 100
    assign sh_l    = both ? (prod_l >> mss_pkg::Q_SHIFT100) : (prod_l >> mss_pkg::Q_SHIFT50);
    assign sh_r    = both ? (prod_r >> mss_pkg::Q_SHIFT100) : (prod_r >> mss_pkg::Q_SHIFT50);
    assign q_l     = sh_l[mss_pkg::DIV_N-1:0];
    assign q_r     = sh_r[mss_pkg::DIV_N-1:0];
    assign qx_l    = signed'(mss_pkg::CALC_W'(q_l));
    assign qx_r    = signed'(mss_pkg::CALC_W'(q_r));
    // quotient truncates toward zero, so the sign goes back on the magnitude
    assign qs_l    = diff_l[mss_pkg::DIV_N] ? -qx_l : qx_l;
    assign qs_r    = diff_r[mss_pkg::DIV_N] ? -qx_r : qx_r;

    always_comb begin
        corr_l = '0;
        corr_r = '0;
        if (both) begin
            corr_r = qs_l;
            corr_l = qs_r;
        end else if (i_item.left_wall) begin
            if (!diff_l[mss_pkg::DIV_N] && (diff_l != '0)) begin
                corr_r = qx_l;
            end else begin
                corr_l = qx_l;
            end
        end else if (i_item.right_wall) begin
            if (!diff_r[mss_pkg::DIV_N] && (diff_r != '0)) begin
                corr_l = qx_r;
            end else begin
                corr_r = qx_r;
            end
        end
    end

    assign ls_f = mss_pkg::sat(mss_pkg::CALC_W'(ls_inc_s) - corr_l);
    assign rs_f = mss_pkg::sat(mss_pkg::CALC_W'(rs_inc_s) - corr_r);

    always_comb begin
        o_state          = i_state;
        o_event.finished = mss_pkg::CMD_NONE;
        o_event.moved_cell = 1'b0;
        if (i_item.action) begin
            o_state.pair = i_item.command_pair;
        end else begin
            o_state.cmd      = cmd0;
            o_state.pair     = pair0;
            o_state.left_sp  = ls0[mss_pkg::SP_WIDTH-1:0];
            o_state.right_sp = rs0[mss_pkg::SP_WIDTH-1:0];
            unique case (cmd0)
                mss_pkg::CMD_FWD: begin
                    if (r_lt_cell) begin
                        o_state.right_sp = rs_inc_s;
                        o_state.left_sp  = ls_abs;
                    end else begin
                        o_event.finished = mss_pkg::CMD_FWD;
                        o_state.cmd      = mss_pkg::CMD_NONE;
                    end
                end
                mss_pkg::CMD_LEFT: begin
                    if (r_lt_turn) begin
                        o_state.right_sp = rs_tl;
                        o_state.left_sp  = ls_tl;
                    end else begin
                        o_event.finished = mss_pkg::CMD_LEFT;
                        o_state.cmd      = mss_pkg::CMD_NONE;
                    end
                end
                mss_pkg::CMD_RIGHT: begin
                    if (l_lt_turn) begin
                        o_state.left_sp  = ls_tr;
                        o_state.right_sp = rs_tr;
                    end else begin
                        o_event.finished = mss_pkg::CMD_RIGHT;
                        o_state.cmd      = mss_pkg::CMD_NONE;
                    end
                end
                mss_pkg::CMD_FWDWAIT: begin
                    if (r_lt_cell) begin
                        // hold position while a front wall is seen
                        if (!i_item.front_wall) begin
                            o_state.right_sp = rs_inc_s;
                            o_state.left_sp  = ls_inc_s;
                        end
                    end else begin
                        o_event.finished = mss_pkg::CMD_FWDWAIT;
                        o_state.cmd      = mss_pkg::CMD_NONE;
                    end
                end
                mss_pkg::CMD_FOLLOW: begin
                    if (follow_go) begin
                        o_state.right_sp = rs_f;
                        o_state.left_sp  = ls_f;
                        o_state.leds     = {i_item.right_wall, i_item.left_wall};
                    end else begin
                        o_event.finished   = mss_pkg::CMD_FOLLOW;
                        o_event.moved_cell = r_gt_half;
                        o_state.cmd        = mss_pkg::CMD_NONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: test/tb_motion_setpoint_sequencer_core.sv
// ----------------------------------------------------------------------------
// tb_motion_setpoint_sequencer_core
// Self-checking bench for the two-wheel motion setpoint sequencer. A short
// table of directed transactions is followed by random traffic under several
// register settings, the extremes included. The bench has its own model of
// the sequencer: it predicts every result, queues the predictions and compares
// each result transaction field by field. Sender bursts, receiver stalls and
// repeated long receiver hold-offs exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_motion_setpoint_sequencer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import mss_pkg::*;

    localparam int     NUM_REGS         = 7;
    localparam int     SENSOR_MAX       = (1 << SENSOR_WIDTH) - 1;
    localparam int     NUM_PHASES       = 7;
    localparam int     ITEMS_PER_PHASE  = 75;
    localparam int     MAX_GAP          = 8;
    localparam int     MAX_BURST        = 16;
    localparam int     DRAIN_CYCLES     = 4;
    localparam int     PATTERN_SPAN     = 50;
    localparam int     HOLD_CYCLES      = 80;
    localparam int     HOLD_SPACING     = 270;
    localparam int     FIRST_HOLD       = 150;
    localparam int     CYCLE_LIMIT      = 200000;
    localparam longint BOTH_WALL_DIV    = 100;
    localparam longint ONE_WALL_DIV     = 50;
    localparam longint SP_MAX           = (longint'(1) <<< (SP_WIDTH - 1)) - 1;
    localparam longint SP_MIN           = -SP_MAX - 1;

    localparam logic [LED_W-1:0] LEDS_OFF   = 2'b00;
    localparam logic [LED_W-1:0] LEDS_LEFT  = 2'b01;
    localparam logic [LED_W-1:0] LEDS_RIGHT = 2'b10;
    localparam logic [LED_W-1:0] LEDS_BOTH  = 2'b11;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_target;
        logic signed [OUT_W-1:0] right_target;
        t_cmd                    active_command;
        t_cmd                    finished;
        logic                    moved_cell;
        logic                    left_lamp;
        logic                    right_lamp;
    } t_setpoints;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_val;
        t_item                  item;
        logic                   typed;
        t_setpoints             want;
    } t_row;

    localparam t_setpoints ALL_IDLE = '0;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_action = 1'b0;
    logic [PAIR_W-1:0]           i_command_pair = '0;
    logic [SENSOR_WIDTH-1:0]     i_front_ir = '0;
    logic [SENSOR_WIDTH-1:0]     i_left_ir = '0;
    logic [SENSOR_WIDTH-1:0]     i_right_ir = '0;
    logic                        i_front_wall = 1'b0;
    logic                        i_left_wall = 1'b0;
    logic                        i_right_wall = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [OUT_W-1:0]     o_left_target;
    logic signed [OUT_W-1:0]     o_right_target;
    logic [CMD_W-1:0]            o_active_command;
    logic [CMD_W-1:0]            o_finished;
    logic                        o_moved_cell;
    logic                        o_left_lamp;
    logic                        o_right_lamp;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    // sequencer model: registers and state
    logic [COUNT_W-1:0] m_cell   = RST_CELL_COUNT;
    logic [COUNT_W-1:0] m_turn   = RST_TURN_COUNT;
    logic [LVL_W-1:0]   m_step   = RST_STEP_SIZE;
    logic [LVL_W-1:0]   m_wall   = RST_WALL_THRESH;
    logic [LVL_W-1:0]   m_near   = RST_FRONT_NEAR;
    logic [LVL_W-1:0]   m_far    = RST_FRONT_FAR;
    logic [LVL_W-1:0]   m_center = RST_SIDE_CENTER;
    t_cmd               m_cmd    = CMD_NONE;
    logic [PAIR_W-1:0]  m_pair   = '0;
    longint             m_left   = 0;
    longint             m_right  = 0;
    logic [LED_W-1:0]   m_leds   = LEDS_OFF;

    t_setpoints pending_setpoints[$];
    int         mismatches = 0;
    int         cycles = 0;
    int         burst_left = 0;

    motion_setpoint_sequencer_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_command_pair   (i_command_pair),
        .i_front_ir       (i_front_ir),
        .i_left_ir        (i_left_ir),
        .i_right_ir       (i_right_ir),
        .i_front_wall     (i_front_wall),
        .i_left_wall      (i_left_wall),
        .i_right_wall     (i_right_wall),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_target    (o_left_target),
        .o_right_target   (o_right_target),
        .o_active_command (o_active_command),
        .o_finished       (o_finished),
        .o_moved_cell     (o_moved_cell),
        .o_left_lamp      (o_left_lamp),
        .o_right_lamp     (o_right_lamp),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint clamp_sp(longint v);
        if (v > SP_MAX) return SP_MAX;
        if (v < SP_MIN) return SP_MIN;
        return v;
    endfunction

    // advance the model by one transaction and return the setpoints it yields
    function automatic t_setpoints next_setpoints(t_item it);
        longint             step, cell_len, turn, ctr, wall, fir, lir, rir, nxt;
        logic [NIB_W-1:0]   first;
        t_cmd               fin;
        logic               moved;
        t_setpoints         r;
        step     = longint'(m_step);
        cell_len = longint'(m_cell);
        turn     = longint'(m_turn);
        ctr      = longint'(m_center);
        wall     = longint'(m_wall);
        fir      = longint'(it.front_ir);
        lir      = longint'(it.left_ir);
        rir      = longint'(it.right_ir);
        fin   = CMD_NONE;
        moved = 1'b0;
        if (it.action) begin
            m_pair = it.command_pair;
        end else begin
            if (m_cmd == CMD_NONE) begin
                first  = m_pair[NIB_W-1:0];
                m_pair = {{NIB_W{1'b0}}, m_pair[PAIR_W-1:NIB_W]};
                // drop codes beyond the last known command
                m_cmd  = (first <= NIB_W'(CMD_FOLLOW)) ? t_cmd'(first[CMD_W-1:0]) : CMD_NONE;
                m_left  = 0;
                m_right = 0;
            end
            case (m_cmd)
                CMD_FWD: begin
                    if (m_right < cell_len) begin
                        m_right = clamp_sp(m_right + step);
                        m_left  = clamp_sp(m_left + step);
                        if (m_left < 0) m_left = clamp_sp(-m_left);
                    end else begin
                        fin   = CMD_FWD;
                        m_cmd = CMD_NONE;
                    end
                end
                CMD_LEFT: begin
                    if (m_right < turn) begin
                        nxt     = m_right + step;
                        m_right = clamp_sp((nxt > turn) ? turn : nxt);
                        nxt     = m_left - step;
                        m_left  = clamp_sp((nxt < -turn) ? -turn : nxt);
                    end else begin
                        fin   = CMD_LEFT;
                        m_cmd = CMD_NONE;
                    end
                end
                CMD_RIGHT: begin
                    if (m_left < turn) begin
                        nxt     = m_left + step;
                        m_left  = clamp_sp((nxt > turn) ? turn : nxt);
                        nxt     = m_right - step;
                        m_right = clamp_sp((nxt < -turn) ? -turn : nxt);
                    end else begin
                        fin   = CMD_RIGHT;
                        m_cmd = CMD_NONE;
                    end
                end
                CMD_FWDWAIT: begin
                    if (m_right < cell_len) begin
                        if (!it.front_wall) begin
                            m_right = clamp_sp(m_right + step);
                            m_left  = clamp_sp(m_left + step);
                        end
                    end else begin
                        fin   = CMD_FWDWAIT;
                        m_cmd = CMD_NONE;
                    end
                end
                CMD_FOLLOW: begin
                    if ((fir > m_far && fir < m_near) || (fir <= m_far && m_right < cell_len)) begin
                        m_right = clamp_sp(m_right + step);
                        m_left  = clamp_sp(m_left + step);
                        m_leds  = LEDS_OFF;
                        // quotients truncate toward zero, so a negative one raises the setpoint
                        if (it.left_wall && it.right_wall) begin
                            m_leds  = LEDS_BOTH;
                            m_right = clamp_sp(m_right - (lir - wall) / BOTH_WALL_DIV);
                            m_left  = clamp_sp(m_left - (rir - wall) / BOTH_WALL_DIV);
                        end else if (it.left_wall) begin
                            m_leds = LEDS_LEFT;
                            if (lir > ctr) m_right = clamp_sp(m_right - (lir - ctr) / ONE_WALL_DIV);
                            else m_left = clamp_sp(m_left - (ctr - lir) / ONE_WALL_DIV);
                        end else if (it.right_wall) begin
                            m_leds = LEDS_RIGHT;
                            if (rir > ctr) m_left = clamp_sp(m_left - (rir - ctr) / ONE_WALL_DIV);
                            else m_right = clamp_sp(m_right - (ctr - rir) / ONE_WALL_DIV);
                        end
                    end else begin
                        fin   = CMD_FOLLOW;
                        m_cmd = CMD_NONE;
                        moved = (m_right > cell_len / 2);
                    end
                end
                default: ;
            endcase
        end
        r.left_target    = m_left[OUT_W-1:0];
        r.right_target   = m_right[OUT_W-1:0];
        r.active_command = m_cmd;
        r.finished       = fin;
        r.moved_cell     = moved;
        r.left_lamp      = m_leds[0];
        r.right_lamp     = m_leds[1];
        return r;
    endfunction

    function automatic t_item tick_item(int fir, int lir, int rir, int fw, int lw, int rw);
        t_item it;
        it            = '0;
        it.front_ir   = SENSOR_WIDTH'(fir);
        it.left_ir    = SENSOR_WIDTH'(lir);
        it.right_ir   = SENSOR_WIDTH'(rir);
        it.front_wall = (fw != 0);
        it.left_wall  = (lw != 0);
        it.right_wall = (rw != 0);
        return it;
    endfunction

    function automatic t_item pair_item(logic [PAIR_W-1:0] pair);
        t_item it;
        it              = '0;
        it.action       = 1'b1;
        it.command_pair = pair;
        return it;
    endfunction

    function automatic t_row predicted_row(t_item it);
        return '{ROW_ITEM, '0, '0, it, 1'b0, ALL_IDLE};
    endfunction

    function automatic t_row typed_row(t_item it, t_setpoints want);
        return '{ROW_ITEM, '0, '0, it, 1'b1, want};
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        return '{ROW_CFG, idx, val, '0, 1'b0, ALL_IDLE};
    endfunction

    // offer one transaction, in bursts with random gaps, and queue its expectation
    task automatic present_item(input t_item it, input logic typed, input t_setpoints want);
        t_setpoints p;
        int         gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, MAX_BURST);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_action       <= it.action;
        i_command_pair <= it.command_pair;
        i_front_ir     <= it.front_ir;
        i_left_ir      <= it.left_ir;
        i_right_ir     <= it.right_ir;
        i_front_wall   <= it.front_wall;
        i_left_wall    <= it.left_wall;
        i_right_wall   <= it.right_wall;
        do @(posedge i_clk); while (!o_in_ready);
        p = next_setpoints(it);
        pending_setpoints.push_back(typed ? want : p);
    endtask

    // drop valid and wait for every outstanding result, then let the pipeline drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_setpoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CELL_COUNT:  m_cell   = val[COUNT_W-1:0];
            CFG_TURN_COUNT:  m_turn   = val[COUNT_W-1:0];
            CFG_STEP_SIZE:   m_step   = val[LVL_W-1:0];
            CFG_WALL_THRESH: m_wall   = val[LVL_W-1:0];
            CFG_FRONT_NEAR:  m_near   = val[LVL_W-1:0];
            CFG_FRONT_FAR:   m_far    = val[LVL_W-1:0];
            CFG_SIDE_CENTER: m_center = val[LVL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: check each transaction, stall on a pattern of its own
    always @(posedge i_clk) begin : result_side
        t_setpoints want;
        int         taken;
        int         pat_cnt;
        int         pat_mode;
        int         hold_left;
        int         next_hold;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            taken     = 0;
            pat_cnt   = 0;
            pat_mode  = 0;
            hold_left = 0;
            next_hold = FIRST_HOLD;
        end else begin
            if (o_out_valid && i_out_ready) begin
                taken++;
                if (pending_setpoints.size() == 0) begin
                    $error("result with no expectation waiting: left_target %0d, right_target %0d",
                           o_left_target, o_right_target);
                    mismatches++;
                end else begin
                    want = pending_setpoints.pop_front();
                    compare_field("left_target", 32'($signed(want.left_target)),
                                  32'($signed(o_left_target)));
                    compare_field("right_target", 32'($signed(want.right_target)),
                                  32'($signed(o_right_target)));
                    compare_field("active_command", 32'(want.active_command),
                                  32'(o_active_command));
                    compare_field("finished", 32'(want.finished), 32'(o_finished));
                    compare_field("moved_cell", 32'(want.moved_cell), 32'(o_moved_cell));
                    compare_field("left_lamp", 32'(want.left_lamp), 32'(o_left_lamp));
                    compare_field("right_lamp", 32'(want.right_lamp), 32'(o_right_lamp));
                end
            end
            pat_cnt++;
            if (pat_cnt % PATTERN_SPAN == 0) pat_mode = $urandom_range(0, 3);
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (taken >= next_hold) begin
                // long hold-off: let the block fill and push back on its input
                hold_left = HOLD_CYCLES;
                next_hold = next_hold + HOLD_SPACING;
                i_out_ready <= 1'b0;
            end else begin
                case (pat_mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_out_ready <= pat_cnt[0];
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_motion_setpoint_sequencer_core NOT OK");
            $finish;
        end
    end

    initial begin
        t_row                  directed[$];
        t_item                 it;
        logic [CFG_DATA_W-1:0] cfg_vals [NUM_REGS];
        logic                  write_now;

        // idle and reset state, then unknown codes: setpoints stay at zero
        directed.push_back(typed_row(tick_item(0, 0, 0, 0, 0, 0), ALL_IDLE));
        directed.push_back(typed_row(pair_item(8'hF6), ALL_IDLE));
        directed.push_back(typed_row(tick_item(SENSOR_MAX, SENSOR_MAX, SENSOR_MAX, 1, 1, 1),
                                     ALL_IDLE));
        directed.push_back(typed_row(tick_item(0, 0, 0, 0, 0, 0), ALL_IDLE));
        // short moves so each command finishes within a few ticks
        directed.push_back(cfg_row(CFG_CELL_COUNT, 16'd40));
        directed.push_back(cfg_row(CFG_TURN_COUNT, 16'd30));
        directed.push_back(cfg_row(CFG_STEP_SIZE, 16'd25));
        directed.push_back(typed_row(pair_item({4'(CMD_LEFT), 4'(CMD_FWD)}), ALL_IDLE));
        repeat (6) directed.push_back(predicted_row(tick_item(0, 0, 0, 0, 0, 0)));
        directed.push_back(predicted_row(pair_item({4'(CMD_FOLLOW), 4'(CMD_RIGHT)})));
        repeat (3) directed.push_back(predicted_row(tick_item(0, 0, 0, 0, 0, 0)));
        directed.push_back(predicted_row(tick_item(200, SENSOR_MAX, 0, 0, 1, 1)));
        directed.push_back(predicted_row(tick_item(200, 0, 0, 0, 1, 0)));
        directed.push_back(predicted_row(tick_item(200, 0, SENSOR_MAX, 0, 0, 1)));
        directed.push_back(predicted_row(tick_item(SENSOR_MAX, 0, 0, 0, 0, 0)));
        directed.push_back(predicted_row(pair_item({4'(CMD_FWDWAIT), 4'(CMD_FWDWAIT)})));
        directed.push_back(predicted_row(tick_item(0, 0, 0, 1, 0, 0)));
        directed.push_back(predicted_row(tick_item(0, 0, 0, 0, 0, 0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) write_reg(directed[i].cfg_idx, directed[i].cfg_val);
            else present_item(directed[i].item, directed[i].typed, directed[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    cfg_vals[CFG_CELL_COUNT]  = CFG_DATA_W'(RST_CELL_COUNT);
                    cfg_vals[CFG_TURN_COUNT]  = CFG_DATA_W'(RST_TURN_COUNT);
                    cfg_vals[CFG_STEP_SIZE]   = CFG_DATA_W'(RST_STEP_SIZE);
                    cfg_vals[CFG_WALL_THRESH] = CFG_DATA_W'(RST_WALL_THRESH);
                    cfg_vals[CFG_FRONT_NEAR]  = CFG_DATA_W'(RST_FRONT_NEAR);
                    cfg_vals[CFG_FRONT_FAR]   = CFG_DATA_W'(RST_FRONT_FAR);
                    cfg_vals[CFG_SIDE_CENTER] = CFG_DATA_W'(RST_SIDE_CENTER);
                end
                1: foreach (cfg_vals[r]) cfg_vals[r] = '0;
                2: foreach (cfg_vals[r]) cfg_vals[r] = '1;
                NUM_PHASES - 1: foreach (cfg_vals[r])
                    cfg_vals[r] = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                default: begin
                    cfg_vals[CFG_CELL_COUNT]  = CFG_DATA_W'($urandom_range(0, 600));
                    cfg_vals[CFG_TURN_COUNT]  = CFG_DATA_W'($urandom_range(0, 400));
                    cfg_vals[CFG_STEP_SIZE]   = CFG_DATA_W'($urandom_range(1, 120));
                    cfg_vals[CFG_WALL_THRESH] = CFG_DATA_W'($urandom_range(0, SENSOR_MAX));
                    cfg_vals[CFG_FRONT_NEAR]  = CFG_DATA_W'($urandom_range(0, SENSOR_MAX));
                    cfg_vals[CFG_FRONT_FAR]   = CFG_DATA_W'($urandom_range(0, 500));
                    cfg_vals[CFG_SIDE_CENTER] = CFG_DATA_W'($urandom_range(0, SENSOR_MAX));
                end
            endcase
            for (int r = 0; r < NUM_REGS; r++) write_reg(CFG_IDX_W'(r), cfg_vals[r]);

            repeat (ITEMS_PER_PHASE) begin
                // queue new commands mostly once the sequencer has run dry
                if (m_cmd == CMD_NONE && m_pair == '0) write_now = ($urandom_range(0, 1) == 0);
                else write_now = ($urandom_range(0, 24) == 0);
                it = '0;
                it.command_pair = PAIR_W'($urandom_range(0, 255));
                if (write_now) begin
                    it.action = 1'b1;
                    if ($urandom_range(0, 9) != 0) begin
                        it.command_pair[NIB_W-1:0] = NIB_W'(($urandom_range(0, 7) == 0) ?
                            $urandom_range(6, 15) : $urandom_range(CMD_NONE, CMD_FOLLOW));
                        it.command_pair[PAIR_W-1:NIB_W] = NIB_W'(($urandom_range(0, 7) == 0) ?
                            $urandom_range(6, 15) : $urandom_range(CMD_NONE, CMD_FOLLOW));
                    end
                end else begin
                    case ($urandom_range(0, 4))
                        0: it.front_ir = SENSOR_WIDTH'($urandom_range(0, m_far));
                        1: it.front_ir = SENSOR_WIDTH'($urandom_range(0, SENSOR_MAX));
                        default: it.front_ir = SENSOR_WIDTH'((m_near > m_far + 1) ?
                            $urandom_range(m_far + 1, m_near - 1) : $urandom_range(0, SENSOR_MAX));
                    endcase
                    it.left_ir    = SENSOR_WIDTH'($urandom_range(0, SENSOR_MAX));
                    it.right_ir   = SENSOR_WIDTH'($urandom_range(0, SENSOR_MAX));
                    it.front_wall = ($urandom_range(0, 3) == 0);
                    it.left_wall  = ($urandom_range(0, 1) == 1);
                    it.right_wall = ($urandom_range(0, 1) == 1);
                end
                present_item(it, 1'b0, ALL_IDLE);
            end
        end

        wait_idle();
        if (pending_setpoints.size() != 0) begin
            $error("%0d expected results never arrived", pending_setpoints.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_motion_setpoint_sequencer_core OK");
        end else begin
            $display("tb_motion_setpoint_sequencer_core NOT OK");
        end
        $finish;
    end

endmodule
